// ===== hdl/ctc_pkg.sv =====
// ctc_pkg: token type codes, character constants and result record
// for the character token classifier; no dependencies
`timescale 1ns / 1ps

package ctc_pkg;

    // open token type codes, five bits so that "no token" fits
    localparam logic [4:0] TY_TEXT    = 5'd0;
    localparam logic [4:0] TY_INT     = 5'd1;
    localparam logic [4:0] TY_FLOAT   = 5'd2;
    localparam logic [4:0] TY_LIT1    = 5'd3;
    localparam logic [4:0] TY_LIT2    = 5'd4;
    localparam logic [4:0] TY_LBRACE  = 5'd5;
    localparam logic [4:0] TY_RBRACE  = 5'd6;
    localparam logic [4:0] TY_LBRACK  = 5'd7;
    localparam logic [4:0] TY_RBRACK  = 5'd8;
    localparam logic [4:0] TY_LPAREN  = 5'd9;
    localparam logic [4:0] TY_RPAREN  = 5'd10;
    localparam logic [4:0] TY_COMMA   = 5'd11;
    localparam logic [4:0] TY_SEMI    = 5'd12;
    localparam logic [4:0] TY_TAB     = 5'd13;
    localparam logic [4:0] TY_SPACE   = 5'd14;
    localparam logic [4:0] TY_NEWLINE = 5'd15;
    localparam logic [4:0] TY_NONE    = 5'd16;

    // character codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LOWER_E = 8'h65;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    // stream widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    // one classification result
    typedef struct packed {
        logic [7:0] char_out;
        logic       closes;
        logic       append_char;
        logic       to_float;
        logic [3:0] token_type;
        logic       start_token;
    } result_t;

endpackage

// ===== hdl/char_token_classifier_top.sv =====
// char_token_classifier_top: byte stream token classifier, one byte per cycle
// while the output is not stalled; depends on ctc_pkg
`timescale 1ns / 1ps

//  channel  | dir | handshake        | tdata fields (lowest bit first)
//  s_axis   | in  | s_tvalid/tready  | ch[7:0], first[8], zero pad [15:9]
//  m_axis   | out | m_tvalid/tready  | start_token, token_type[4:1], to_float,
//           |     |                  | append_char, closes, char_out[15:8]
//
// one byte per cycle sustained while the output is not stalled; a transferred
// byte passes through the input register, then the result register, to the output
// the open token type is updated as the byte leaves the input register
// reset returns to "no open token" and empties both registers
// a stalled output holds both stages; each stage frees itself when it moves on

module char_token_classifier_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // ch[7:0], first[8], zero [15:9]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // start_token, token_type[4:1], to_float,
                                   // append_char, closes, char_out[15:8]
);

    logic                 in_valid_reg;
    logic [7:0]           in_ch_reg;
    logic                 in_first_reg;
    logic                 out_valid_reg;
    ctc_pkg::result_t     out_reg;
    ctc_pkg::result_t     out_next;
    logic [4:0]           open_type_reg;
    logic [4:0]           open_type_next;
    logic                 advance;

    // stage movement
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_ch_reg    <= s_tdata[7:0];
            in_first_reg <= s_tdata[8];
        end
    end

    // classification of the registered byte against the open token
    always_comb
    begin
        logic [7:0] c;
        logic [4:0] t;
        logic [4:0] ty;
        logic [4:0] lt;
        logic       start;
        logic       tofl;
        logic       app;
        c     = in_ch_reg;
        t     = in_first_reg ? ctc_pkg::TY_NONE : open_type_reg;
        ty    = ctc_pkg::TY_TEXT;
        lt    = ctc_pkg::TY_LIT1;
        start = 1'b0;
        tofl  = 1'b0;
        app   = 1'b0;
        if (c == ctc_pkg::CH_NUL)
        begin
            // ignored byte, open type kept unless the first flag clears it
        end
        else if (c == ctc_pkg::CH_LBRACE || c == ctc_pkg::CH_RBRACE ||
                 c == ctc_pkg::CH_LBRACK || c == ctc_pkg::CH_RBRACK ||
                 c == ctc_pkg::CH_LPAREN || c == ctc_pkg::CH_RPAREN)
        begin
            case (c)
                ctc_pkg::CH_LBRACE: ty = ctc_pkg::TY_LBRACE;
                ctc_pkg::CH_RBRACE: ty = ctc_pkg::TY_RBRACE;
                ctc_pkg::CH_LBRACK: ty = ctc_pkg::TY_LBRACK;
                ctc_pkg::CH_RBRACK: ty = ctc_pkg::TY_RBRACK;
                ctc_pkg::CH_LPAREN: ty = ctc_pkg::TY_LPAREN;
                default:            ty = ctc_pkg::TY_RPAREN;
            endcase
            start = 1'b1;
            app   = 1'b1;
            t     = ctc_pkg::TY_NONE;
        end
        else if (c == ctc_pkg::CH_COMMA || c == ctc_pkg::CH_TAB || c == ctc_pkg::CH_NL)
        begin
            if (t == ctc_pkg::TY_NONE || t == ctc_pkg::TY_TEXT)
            begin
                case (c)
                    ctc_pkg::CH_COMMA: t = ctc_pkg::TY_COMMA;
                    ctc_pkg::CH_TAB:   t = ctc_pkg::TY_TAB;
                    default:           t = ctc_pkg::TY_NEWLINE;
                endcase
                start = 1'b1;
            end
            ty  = t;
            app = 1'b1;
        end
        else if (c == ctc_pkg::CH_SEMI)
        begin
            if (t == ctc_pkg::TY_NONE || t == ctc_pkg::TY_TEXT || t == ctc_pkg::TY_LIT1 ||
                t == ctc_pkg::TY_LIT2 || t == ctc_pkg::TY_INT || t == ctc_pkg::TY_FLOAT)
            begin
                t     = ctc_pkg::TY_SEMI;
                start = 1'b1;
            end
            ty  = t;
            app = 1'b1;
        end
        else if (c == ctc_pkg::CH_SPACE)
        begin
            if (t == ctc_pkg::TY_NONE || t == ctc_pkg::TY_TEXT || t == ctc_pkg::TY_INT)
            begin
                t     = ctc_pkg::TY_SPACE;
                start = 1'b1;
            end
            ty  = t;
            app = 1'b1;
        end
        else if (c == ctc_pkg::CH_DQUOTE || c == ctc_pkg::CH_SQUOTE)
        begin
            // quotes toggle a literal of their own kind, never stored
            lt = (c == ctc_pkg::CH_DQUOTE) ? ctc_pkg::TY_LIT2 : ctc_pkg::TY_LIT1;
            ty = lt;
            if (t == lt)
            begin
                t = ctc_pkg::TY_NONE;
            end
            else
            begin
                t     = lt;
                start = 1'b1;
            end
        end
        else if (c >= ctc_pkg::CH_ZERO && c <= ctc_pkg::CH_NINE)
        begin
            if (!(t == ctc_pkg::TY_TEXT || t == ctc_pkg::TY_LIT1 || t == ctc_pkg::TY_LIT2 ||
                  t == ctc_pkg::TY_FLOAT || t == ctc_pkg::TY_INT))
            begin
                t     = ctc_pkg::TY_INT;
                start = 1'b1;
            end
            ty  = t;
            app = 1'b1;
        end
        else if (t == ctc_pkg::TY_INT &&
                 (c == ctc_pkg::CH_LOWER_E || c == ctc_pkg::CH_UPPER_E ||
                  c == ctc_pkg::CH_LOWER_F || c == ctc_pkg::CH_UPPER_F ||
                  c == ctc_pkg::CH_DOT))
        begin
            // integer becomes float; an f suffix also ends it
            tofl = 1'b1;
            app  = 1'b1;
            ty   = ctc_pkg::TY_FLOAT;
            t    = (c == ctc_pkg::CH_LOWER_F || c == ctc_pkg::CH_UPPER_F) ?
                   ctc_pkg::TY_NONE : ctc_pkg::TY_FLOAT;
        end
        else
        begin
            if (!(t == ctc_pkg::TY_TEXT || t == ctc_pkg::TY_LIT1 || t == ctc_pkg::TY_LIT2 ||
                  t == ctc_pkg::TY_FLOAT))
            begin
                t     = ctc_pkg::TY_TEXT;
                start = 1'b1;
            end
            ty  = t;
            app = 1'b1;
        end
        open_type_next       = t;
        out_next.start_token = start;
        out_next.token_type  = ty[3:0];
        out_next.to_float    = tofl;
        out_next.append_char = app;
        out_next.closes      = (c != ctc_pkg::CH_NUL) && (t == ctc_pkg::TY_NONE);
        out_next.char_out    = c;
    end

    // open token state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_type_reg <= ctc_pkg::TY_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                open_type_reg <= open_type_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    // a non-null byte reports closed exactly when no token remains open
    a_closes_state: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_ch_reg != ctc_pkg::CH_NUL) |=>
        (out_reg.closes == (open_type_reg == ctc_pkg::TY_NONE)))
        else $error("closes flag disagrees with open token state");

    // a retype to float always reports float and appends
    a_float_retype: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.to_float) |->
        (out_reg.token_type == ctc_pkg::TY_FLOAT[3:0] && out_reg.append_char))
        else $error("float retype without float type or append");

    // bracket tokens are never left open
    a_no_open_bracket: assert property (@(posedge clk) disable iff (!rst_n)
        !(open_type_reg == ctc_pkg::TY_LBRACE || open_type_reg == ctc_pkg::TY_RBRACE ||
          open_type_reg == ctc_pkg::TY_LBRACK || open_type_reg == ctc_pkg::TY_RBRACK ||
          open_type_reg == ctc_pkg::TY_LPAREN || open_type_reg == ctc_pkg::TY_RPAREN))
        else $error("bracket token left open");

    // a byte leaving the input stage always lands in the result register
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_valid_reg && out_reg.char_out == $past(in_ch_reg)))
        else $error("advanced byte not in result register");

endmodule

// ===== test/ctc_checker.sv =====
// ctc_checker: watches both stream channels of the token classifier, predicts
// each result from the accepted bytes and compares field by field; uses ctc_pkg
`timescale 1ns / 1ps

module ctc_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // ch[7:0], first[8], zero [15:9]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // start_token, token_type[4:1], to_float,
                                   // append_char, closes, char_out[15:8]
    output int          errors,
    output int          pending
);

    // predicted results waiting for their output transfer
    ctc_pkg::result_t results_due[$];
    // type of the token open after the last accepted byte
    logic [4:0]       open_ty;
    ctc_pkg::result_t got;
    ctc_pkg::result_t want;
    int               mismatches = 0;

    assign errors = mismatches;

    task automatic report_mismatch(input string what, input int got_val, input int want_val);
        $display("%0t ns ctc_checker: %s got %0d, predicted %0d", $time, what, got_val, want_val);
        mismatches++;
    endtask

    function automatic logic is_literal(input logic [4:0] ty);
        return ty == ctc_pkg::TY_LIT1 || ty == ctc_pkg::TY_LIT2;
    endfunction

    // classify one byte and advance the open token type
    function automatic ctc_pkg::result_t classify_byte(input logic [7:0] c,
                                                       input logic new_text);
        ctc_pkg::result_t r;
        logic [4:0]       t;
        logic [4:0]       ty;
        logic [4:0]       quote_ty;
        r = '0;
        r.char_out = c;
        t = new_text ? ctc_pkg::TY_NONE : open_ty;
        ty = ctc_pkg::TY_TEXT;
        if (c == ctc_pkg::CH_NUL)
        begin
            open_ty = t;
            return r;
        end
        if (c == ctc_pkg::CH_LBRACE || c == ctc_pkg::CH_RBRACE ||
            c == ctc_pkg::CH_LBRACK || c == ctc_pkg::CH_RBRACK ||
            c == ctc_pkg::CH_LPAREN || c == ctc_pkg::CH_RPAREN)
        begin
            // one-byte tokens
            case (c)
                ctc_pkg::CH_LBRACE: ty = ctc_pkg::TY_LBRACE;
                ctc_pkg::CH_RBRACE: ty = ctc_pkg::TY_RBRACE;
                ctc_pkg::CH_LBRACK: ty = ctc_pkg::TY_LBRACK;
                ctc_pkg::CH_RBRACK: ty = ctc_pkg::TY_RBRACK;
                ctc_pkg::CH_LPAREN: ty = ctc_pkg::TY_LPAREN;
                default:            ty = ctc_pkg::TY_RPAREN;
            endcase
            r.start_token = 1'b1;
            r.append_char = 1'b1;
            t = ctc_pkg::TY_NONE;
        end
        else if (c == ctc_pkg::CH_COMMA || c == ctc_pkg::CH_TAB || c == ctc_pkg::CH_NL)
        begin
            if (t == ctc_pkg::TY_NONE || t == ctc_pkg::TY_TEXT)
            begin
                t = (c == ctc_pkg::CH_COMMA) ? ctc_pkg::TY_COMMA :
                    (c == ctc_pkg::CH_TAB)   ? ctc_pkg::TY_TAB : ctc_pkg::TY_NEWLINE;
                r.start_token = 1'b1;
            end
            ty = t;
            r.append_char = 1'b1;
        end
        else if (c == ctc_pkg::CH_SEMI)
        begin
            if (t == ctc_pkg::TY_NONE || t == ctc_pkg::TY_TEXT || is_literal(t) ||
                t == ctc_pkg::TY_INT || t == ctc_pkg::TY_FLOAT)
            begin
                t = ctc_pkg::TY_SEMI;
                r.start_token = 1'b1;
            end
            ty = t;
            r.append_char = 1'b1;
        end
        else if (c == ctc_pkg::CH_SPACE)
        begin
            if (t == ctc_pkg::TY_NONE || t == ctc_pkg::TY_TEXT || t == ctc_pkg::TY_INT)
            begin
                t = ctc_pkg::TY_SPACE;
                r.start_token = 1'b1;
            end
            ty = t;
            r.append_char = 1'b1;
        end
        else if (c == ctc_pkg::CH_DQUOTE || c == ctc_pkg::CH_SQUOTE)
        begin
            // quotes open or close a literal and are never stored
            quote_ty = (c == ctc_pkg::CH_DQUOTE) ? ctc_pkg::TY_LIT2 : ctc_pkg::TY_LIT1;
            ty = quote_ty;
            if (t == quote_ty)
                t = ctc_pkg::TY_NONE;
            else
            begin
                t = quote_ty;
                r.start_token = 1'b1;
            end
        end
        else if (c >= ctc_pkg::CH_ZERO && c <= ctc_pkg::CH_NINE)
        begin
            if (!(t == ctc_pkg::TY_TEXT || is_literal(t) || t == ctc_pkg::TY_FLOAT ||
                  t == ctc_pkg::TY_INT))
            begin
                t = ctc_pkg::TY_INT;
                r.start_token = 1'b1;
            end
            ty = t;
            r.append_char = 1'b1;
        end
        else if (t == ctc_pkg::TY_INT &&
                 (c == ctc_pkg::CH_LOWER_E || c == ctc_pkg::CH_UPPER_E ||
                  c == ctc_pkg::CH_DOT ||
                  c == ctc_pkg::CH_LOWER_F || c == ctc_pkg::CH_UPPER_F))
        begin
            // integer retyped as float; an f suffix also ends it
            r.to_float = 1'b1;
            r.append_char = 1'b1;
            ty = ctc_pkg::TY_FLOAT;
            t = (c == ctc_pkg::CH_LOWER_F || c == ctc_pkg::CH_UPPER_F) ?
                ctc_pkg::TY_NONE : ctc_pkg::TY_FLOAT;
        end
        else
        begin
            if (!(t == ctc_pkg::TY_TEXT || is_literal(t) || t == ctc_pkg::TY_FLOAT))
            begin
                t = ctc_pkg::TY_TEXT;
                r.start_token = 1'b1;
            end
            ty = t;
            r.append_char = 1'b1;
        end
        open_ty = t;
        r.token_type = ty[3:0];
        r.closes = (t == ctc_pkg::TY_NONE);
        return r;
    endfunction

    // compare results first, then predict from the input transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_due.delete();
            open_ty = ctc_pkg::TY_NONE;
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (results_due.size() == 0)
                    report_mismatch("result with none pending, char_out", got.char_out, -1);
                else
                begin
                    want = results_due.pop_front();
                    if (got.start_token !== want.start_token)
                        report_mismatch("start_token", got.start_token, want.start_token);
                    if (got.token_type !== want.token_type)
                        report_mismatch("token_type", got.token_type, want.token_type);
                    if (got.to_float !== want.to_float)
                        report_mismatch("to_float", got.to_float, want.to_float);
                    if (got.append_char !== want.append_char)
                        report_mismatch("append_char", got.append_char, want.append_char);
                    if (got.closes !== want.closes)
                        report_mismatch("closes", got.closes, want.closes);
                    if (got.char_out !== want.char_out)
                        report_mismatch("char_out", got.char_out, want.char_out);
                end
            end
            if (s_tvalid && s_tready)
                results_due.push_back(classify_byte(s_tdata[7:0], s_tdata[8]));
            pending <= results_due.size();
        end
    end

endmodule

// ===== test/tb_char_token_classifier_top.sv =====
// tb_char_token_classifier_top: stimulus and verdict for the token classifier,
// directed bytes then token-shaped random text with random stalls on both sides
// depends on ctc_pkg, char_token_classifier_top and ctc_checker
`timescale 1ns / 1ps

module tb_char_token_classifier_top;

    localparam int RANDOM_ITEMS = 650;
    localparam int PRESSURE_AT  = 350;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_MIN     = 8'h01;
    localparam logic [7:0] CH_MAX     = 8'hFF;
    localparam logic [7:0] CH_HIGH    = 8'h80;

    localparam logic [47:0] BRACKET_SET   = {ctc_pkg::CH_LBRACE, ctc_pkg::CH_RBRACE,
                                             ctc_pkg::CH_LBRACK, ctc_pkg::CH_RBRACK,
                                             ctc_pkg::CH_LPAREN, ctc_pkg::CH_RPAREN};
    localparam logic [39:0] SEPARATOR_SET = {ctc_pkg::CH_COMMA, ctc_pkg::CH_SEMI,
                                             ctc_pkg::CH_TAB, ctc_pkg::CH_SPACE,
                                             ctc_pkg::CH_NL};
    localparam logic [39:0] FLOAT_MARKS   = {ctc_pkg::CH_LOWER_E, ctc_pkg::CH_UPPER_E,
                                             ctc_pkg::CH_DOT, ctc_pkg::CH_LOWER_F,
                                             ctc_pkg::CH_UPPER_F};

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    int errors;
    int pending;
    int bytes_sent  = 0;
    int cycle_count = 0;
    bit gapless     = 1'b0;
    bit hold_req    = 1'b0;

    always #2 clk = ~clk;

    char_token_classifier_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ctc_checker u_checker
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    // idle stretch length: mostly short, a few long
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] digit();
        return ctc_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] letter();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
        return 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
    endfunction

    function automatic logic new_text();
        return $urandom_range(0, 39) == 0;
    endfunction

    // offer one byte after an optional gap and hold it until the transfer
    task automatic send_byte(input logic [7:0] c, input logic first_flag);
        int gap;
        gap = (gapless || $urandom_range(0, 99) < 60) ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, first_flag, c};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // cycle limit
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_char_token_classifier_top NOT OK");
        $finish;
    end

    // output side: random stalls, a long hold-off on each request
    initial
    begin : receiver
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if ($urandom_range(0, 99) < 55)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat (idle_len()) @(posedge clk);
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        int         n;
        logic [7:0] quote;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // integer, fraction, exponent letter inside a float, space over a float
        send_byte(ctc_pkg::CH_ZERO + 8'd1, 1'b1);
        send_byte(ctc_pkg::CH_NINE, 1'b0);
        send_byte(ctc_pkg::CH_DOT, 1'b0);
        send_byte(ctc_pkg::CH_ZERO + 8'd5, 1'b0);
        send_byte(ctc_pkg::CH_LOWER_E, 1'b0);
        send_byte(ctc_pkg::CH_SPACE, 1'b0);
        // f suffix closes, E retypes, semicolon over float, comma over semicolon
        send_byte(ctc_pkg::CH_ZERO + 8'd7, 1'b1);
        send_byte(ctc_pkg::CH_LOWER_F, 1'b0);
        send_byte(ctc_pkg::CH_ZERO, 1'b0);
        send_byte(ctc_pkg::CH_UPPER_E, 1'b0);
        send_byte(ctc_pkg::CH_SEMI, 1'b0);
        send_byte(ctc_pkg::CH_COMMA, 1'b0);
        // text then tab, double quote, then an empty literal of the other kind
        send_byte(CH_LOWER_A, 1'b0);
        send_byte(ctc_pkg::CH_TAB, 1'b0);
        send_byte(ctc_pkg::CH_DQUOTE, 1'b0);
        send_byte(ctc_pkg::CH_SQUOTE, 1'b0);
        send_byte(ctc_pkg::CH_SQUOTE, 1'b0);
        // all one-byte tokens
        for (int i = 0; i < 6; i++)
            send_byte(BRACKET_SET[8*i +: 8], 1'b0);
        // byte extremes and high bytes that are never digits
        send_byte(CH_MAX, 1'b0);
        send_byte(ctc_pkg::CH_NL, 1'b0);
        send_byte(CH_HIGH, 1'b1);
        send_byte(CH_MIN, 1'b0);

        // token-shaped random text with some noise
        while (bytes_sent < RANDOM_ITEMS + 25)
        begin
            if ($urandom_range(0, 19) == 0)
                gapless = ~gapless;
            if (bytes_sent >= PRESSURE_AT && bytes_sent < PRESSURE_AT + 8)
                hold_req = 1'b1;
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    // integer
                    n = $urandom_range(1, 4);
                    repeat (n) send_byte(digit(), new_text());
                end
                2:
                begin
                    // float with a marker and optional tail
                    n = $urandom_range(1, 3);
                    repeat (n) send_byte(digit(), new_text());
                    send_byte(FLOAT_MARKS[8*$urandom_range(0, 4) +: 8], new_text());
                    n = $urandom_range(0, 3);
                    repeat (n) send_byte(digit(), new_text());
                end
                3:
                begin
                    // identifier
                    send_byte(letter(), new_text());
                    n = $urandom_range(0, 5);
                    repeat (n) send_byte($urandom_range(0, 2) == 0 ? digit() : letter(),
                                         new_text());
                end
                4:
                begin
                    // quoted literal, content may hold separators and the other quote
                    quote = $urandom_range(0, 1) ? ctc_pkg::CH_DQUOTE : ctc_pkg::CH_SQUOTE;
                    send_byte(quote, new_text());
                    n = $urandom_range(0, 5);
                    repeat (n)
                    begin
                        case ($urandom_range(0, 3))
                            0:       send_byte(digit(), new_text());
                            1:       send_byte(SEPARATOR_SET[8*$urandom_range(0, 4) +: 8],
                                               new_text());
                            2:       send_byte(quote == ctc_pkg::CH_DQUOTE ?
                                               ctc_pkg::CH_SQUOTE : ctc_pkg::CH_DQUOTE,
                                               new_text());
                            default: send_byte(letter(), new_text());
                        endcase
                    end
                    send_byte(quote, new_text());
                end
                5:
                    send_byte(BRACKET_SET[8*$urandom_range(0, 5) +: 8], new_text());
                6, 7:
                    send_byte(SEPARATOR_SET[8*$urandom_range(0, 4) +: 8], new_text());
                8:
                begin
                    // noise over every nonzero byte value
                    n = $urandom_range(1, 3);
                    repeat (n) send_byte(8'($urandom_range(CH_MIN, CH_MAX)), new_text());
                end
                default:
                    send_byte(ctc_pkg::CH_SPACE, new_text());
            endcase
        end
        s_tvalid <= 1'b0;

        // let the last transfer reach the checker, then drain
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb_char_token_classifier_top OK");
        else
            $display("tb_char_token_classifier_top NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ctc_pkg.sv
hdl/char_token_classifier_top.sv
test/ctc_checker.sv
test/tb_char_token_classifier_top.sv
